// ===== rtl/buddy_page_allocator_core_defines.svh =====
// Assertion macros used by the buddy page allocator core
`ifndef BUDDY_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define BPA_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define BPA_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define BPA_ASSERT_IMP(lbl, pre, post, msg)
`define BPA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/bpa_pkg.sv =====
// Types and codes shared by the buddy page allocator modules
`default_nettype none
package bpa_pkg;

    localparam int LVL_W = 5;
    typedef logic [LVL_W-1:0] lvl_t;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [12:0] page_count;
        logic [11:0] free_page;
    } bpa_in_t;

    typedef struct packed {
        logic [11:0] first_page;
        logic [1:0]  status;
    } bpa_out_t;

    // Request classification handed from the decoder to the tree walker
    typedef struct packed {
        logic       is_free;
        logic       reject;
        logic [1:0] reject_status;
        lvl_t       want_lvl;
    } bpa_req_t;

endpackage
`default_nettype wire

// ===== rtl/bpa_req_decode.sv =====
// Request decoder: size rounding and early rejection
`default_nettype none
module bpa_req_decode
    import bpa_pkg::*;
#(
    parameter int POOL_LEVELS = 12
)
(
    input  wire bpa_in_t req,
    output bpa_req_t     dec
);

    localparam int unsigned POOL = 1 << POOL_LEVELS;

    logic [12:0] count_m1;
    lvl_t        want_lvl;

    // Bit length of count-1 is the log2 of the rounded-up size
    always_comb
    begin
        count_m1 = (req.page_count == 13'd0) ? 13'd0 : req.page_count - 13'd1;
        want_lvl = '0;
        for (int i = 0; i < 13; i++)
        begin
            if (count_m1[i])
            begin
                want_lvl = LVL_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        dec.is_free       = (req.mode == MODE_FREE);
        dec.want_lvl      = want_lvl;
        dec.reject        = 1'b0;
        dec.reject_status = ST_OK;
        if (req.mode == MODE_ALLOC)
        begin
            if (want_lvl > LVL_W'(POOL_LEVELS))
            begin
                dec.reject        = 1'b1;
                dec.reject_status = ST_NOSPACE;
            end
        end
        else
        begin
            if (32'(req.free_page) >= POOL)
            begin
                dec.reject        = 1'b1;
                dec.reject_status = ST_BADFREE;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/buddy_page_allocator_core.sv =====
// A rejected request is answered from idle without a tree walk. An allocate reads the root,
// stops there if no run is large enough, else descends to the wanted level, marks the node
// and updates its ancestors; a free climbs from its leaf to the used node, then merges up.
// One request at a time; one tree level per cycle, set by the single read port of the tree.
// After reset a clearing pass writes all 2*POOL-1 nodes, busy high throughout. Results are
// strobed on done for one cycle; no backpressure.
`default_nettype none
`include "buddy_page_allocator_core_defines.svh"
module buddy_page_allocator_core
    import bpa_pkg::*;
#(
    parameter int TOTAL_PAGES = 4096
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire bpa_in_t req,
    output logic         done,
    output bpa_out_t     rsp
);

    localparam int LEVELS     = (TOTAL_PAGES > 1) ? $clog2(TOTAL_PAGES) : 1;
    localparam int POOL       = 1 << LEVELS;
    localparam int NODE_COUNT = 2 * POOL - 1;
    localparam int IW         = LEVELS + 1;
    localparam int VW         = LEVELS + 1;

    localparam logic [IW-1:0] LAST_NODE = IW'(NODE_COUNT - 1);
    localparam logic [IW-1:0] LEAF_BASE = IW'(POOL - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ROOT,
        S_DOWN,
        S_MARK,
        S_UP,
        S_FREE_CHK
    } state_t;

    state_t            state_reg, state_next;
    logic [IW-1:0]     idx_reg, idx_next;
    lvl_t              lvl_reg, lvl_next;
    logic [VW-1:0]     cur_val_reg, cur_val_next;
    lvl_t              want_reg, want_next;
    logic [LEVELS-1:0] page_reg, page_next;
    bpa_out_t          rsp_reg, rsp_next;
    logic              done_reg, done_next;

    bpa_req_t dec;

    logic [VW-1:0] tree_mem [NODE_COUNT];
    logic [VW-1:0] mem_q;
    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [VW-1:0] mem_wdata;

    logic [IW-1:0]     left_idx, down_idx, down_left, sib_idx, parent_idx, parent_sib;
    logic [IW-1:0]     leaf_idx, page_span, alloc_span;
    logic [IW:0]       clr_n;
    logic              clr_pow2;
    logic [VW-1:0]     want_size, restore_val, pmax, pval;
    logic [VW:0]       sum_ext, psize_ext;
    lvl_t              plvl;
    logic [LEVELS:0]   mask_full;
    logic              aligned;
    logic [LEVELS-1:0] req_page;

    bpa_req_decode #(
        .POOL_LEVELS(LEVELS)
    ) u_decode (
        .req(req),
        .dec(dec)
    );

    // Tree store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tree_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= tree_mem[mem_raddr];
        end
    end

    always_comb
    begin
        req_page    = LEVELS'(req.free_page);
        leaf_idx    = LEAF_BASE + IW'(req_page);
        left_idx    = {idx_reg[IW-2:0], 1'b1};
        want_size   = VW'(1) << want_reg;
        down_idx    = (mem_q >= want_size) ? left_idx : left_idx + IW'(1);
        down_left   = {down_idx[IW-2:0], 1'b1};
        sib_idx     = idx_reg[0] ? idx_reg + IW'(1) : idx_reg - IW'(1);
        parent_idx  = (idx_reg - IW'(1)) >> 1;
        parent_sib  = parent_idx[0] ? parent_idx + IW'(1) : parent_idx - IW'(1);
        clr_n       = (IW+1)'(idx_reg) + (IW+1)'(2);
        clr_pow2    = ((clr_n & (clr_n - (IW+1)'(1))) == '0);
        page_span   = (idx_reg + IW'(1)) << lvl_reg;
        alloc_span  = page_span - IW'(POOL);
        restore_val = VW'(1) << lvl_reg;
        mask_full   = ((LEVELS+1)'(1) << lvl_reg) - (LEVELS+1)'(1);
        aligned     = ((page_reg & mask_full[LEVELS-1:0]) == '0);
        plvl        = lvl_reg + LVL_W'(1);
        sum_ext     = {1'b0, cur_val_reg} + {1'b0, mem_q};
        psize_ext   = (VW+1)'(1) << plvl;
        pmax        = (cur_val_reg > mem_q) ? cur_val_reg : mem_q;
        // Merge two wholly free buddies, else keep the larger child
        pval        = (sum_ext == psize_ext) ? psize_ext[VW-1:0] : pmax;
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        lvl_next     = lvl_reg;
        cur_val_next = cur_val_reg;
        want_next    = want_reg;
        page_next    = page_reg;
        rsp_next     = rsp_reg;
        done_next    = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = idx_reg;
        mem_raddr    = idx_reg;
        mem_wdata    = cur_val_reg;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (idx_reg == LAST_NODE)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                    if (clr_pow2)
                    begin
                        cur_val_next = cur_val_reg >> 1;
                    end
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    want_next           = dec.want_lvl;
                    page_next           = req_page;
                    rsp_next.first_page = '0;
                    if (dec.reject)
                    begin
                        rsp_next.status = dec.reject_status;
                        done_next       = 1'b1;
                    end
                    else if (dec.is_free)
                    begin
                        idx_next   = leaf_idx;
                        lvl_next   = '0;
                        mem_re     = 1'b1;
                        mem_raddr  = leaf_idx;
                        state_next = S_FREE_CHK;
                    end
                    else
                    begin
                        idx_next   = '0;
                        lvl_next   = LVL_W'(LEVELS);
                        mem_re     = 1'b1;
                        mem_raddr  = '0;
                        state_next = S_ROOT;
                    end
                end
            end
            S_ROOT:
            begin
                if (mem_q < want_size)
                begin
                    rsp_next.status = ST_NOSPACE;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (lvl_reg == want_reg)
                begin
                    state_next = S_MARK;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = left_idx;
                    state_next = S_DOWN;
                end
            end
            S_DOWN:
            begin
                // Prefer the left child when it holds a large enough run
                idx_next = down_idx;
                lvl_next = lvl_reg - LVL_W'(1);
                if (lvl_reg - LVL_W'(1) == want_reg)
                begin
                    state_next = S_MARK;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = down_left;
                end
            end
            S_MARK:
            begin
                mem_we              = 1'b1;
                mem_wdata           = '0;
                cur_val_next        = '0;
                rsp_next.first_page = 12'(alloc_span[LEVELS-1:0]);
                if (idx_reg == '0)
                begin
                    rsp_next.status = ST_OK;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = sib_idx;
                    state_next = S_UP;
                end
            end
            S_UP:
            begin
                mem_we       = 1'b1;
                mem_waddr    = parent_idx;
                mem_wdata    = pval;
                idx_next     = parent_idx;
                lvl_next     = plvl;
                cur_val_next = pval;
                if (parent_idx == '0)
                begin
                    rsp_next.status = ST_OK;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = parent_sib;
                end
            end
            S_FREE_CHK:
            begin
                if (mem_q == '0)
                begin
                    if (aligned)
                    begin
                        mem_we       = 1'b1;
                        mem_wdata    = restore_val;
                        cur_val_next = restore_val;
                        if (idx_reg == '0)
                        begin
                            rsp_next.status = ST_OK;
                            done_next       = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = sib_idx;
                            state_next = S_UP;
                        end
                    end
                    else
                    begin
                        rsp_next.status = ST_BADFREE;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else if (idx_reg == '0)
                begin
                    rsp_next.status = ST_BADFREE;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    // Climb toward the root looking for the used node
                    idx_next  = parent_idx;
                    lvl_next  = plvl;
                    mem_re    = 1'b1;
                    mem_raddr = parent_idx;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            idx_reg     <= '0;
            lvl_reg     <= '0;
            cur_val_reg <= VW'(POOL);
            want_reg    <= '0;
            page_reg    <= '0;
            rsp_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            lvl_reg     <= lvl_next;
            cur_val_reg <= cur_val_next;
            want_reg    <= want_next;
            page_reg    <= page_next;
            rsp_reg     <= rsp_next;
            done_reg    <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `BPA_ASSERT_IMP(a_no_rw_collide, mem_we && mem_re, mem_raddr != mem_waddr, "tree read and write hit the same node")
    `BPA_ASSERT_IMP(a_no_done_in_clear, state_reg == S_CLEAR, !done, "result beat during clearing pass")
    `BPA_ASSERT_IMP(a_walk_ends_with_beat, state_reg == S_IDLE && $past(state_reg) != S_IDLE && $past(state_reg) != S_CLEAR, done, "walk ended without a result beat")
    `BPA_ASSERT_NEXT(a_reject_beat, state_reg == S_IDLE && start && dec.reject, done && !busy, "rejected request gave no immediate beat")

endmodule
`default_nettype wire
